>>> rtl/rsi_pkg.sv
package rsi_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_BITS = 3;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // status codes
    localparam logic [1:0] ST_HIT    = 2'd0;
    localparam logic [1:0] ST_DEGEN  = 2'd1;
    localparam logic [1:0] ST_NOROOT = 2'd2;
    localparam logic [1:0] ST_BEHIND = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS   = 3'd3;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
        t_coord end_x;
        t_coord end_y;
        t_coord end_z;
    } t_ray_in;

    typedef struct packed {
        logic [1:0] status;
        t_coord     hit_distance;
        t_coord     root_plus;
        t_coord     root_minus;
    } t_ray_out;

endpackage

>>> rtl/ray_sphere_intersect_core.sv
// Roots and hit distance carry FRAC_BITS fraction bits (Q16.16 at the default).
// Throughput: one ray per cycle; the whole pipeline advances on a single enable.
// The enable drops only while the output register holds a result and the sink stalls.
// Depth is set by the bit-serial square root (one root bit per stage) and the
// two restoring divider lanes (one quotient bit per stage).
// Reset (i_rst_n low, synchronous) clears all valid bits and the sphere registers.
module ray_sphere_intersect_core #(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rsi_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [rsi_pkg::COORD_BITS-1:0]   i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  rsi_pkg::t_ray_in                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output rsi_pkg::t_ray_out               o_out_data
);
    import rsi_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int H  = N + 1;                 // half width of the wide products
    localparam int RW = 2 * H;                 // |A|, |B|, |K| magnitude width
    localparam int PW = RW + 1;                // signed A, B, K
    localparam int DW = 4 * H + 2;             // signed discriminant
    localparam int XW = 4 * N + 6 + 2 * FRAC_BITS; // radicand, even
    localparam int QW = XW / 2;                // root width
    localparam int NW = 2 * N + 5 + FRAC_BITS; // signed numerator
    localparam int DS = N + 1;                 // quotient bits computed

    // |d|^2 * 10000 < 2^(2F)  <=>  A < ceil(2^(2F) / 10000)
    localparam logic [RW-1:0] DEG_LIM =
        RW'(((64'd1 << (2 * FRAC_BITS)) + 64'd9999) / 64'd10000);
    localparam logic [DS:0] POS_MAX = (DS+1)'((64'd1 << (N - 1)) - 64'd1);
    localparam logic [DS:0] NEG_MAX = (DS+1)'(64'd1 << (N - 1));

    typedef struct packed {
        logic                 deg;
        logic                 neg;
        logic signed [PW-1:0] b;
        logic [RW-1:0]        a;
    } t_sq_side;

    typedef struct packed {
        logic          deg;
        logic          neg;
        logic [RW-1:0] a;
        logic [1:0]    sgn;
        logic [1:0]    ovf;
    } t_dv_side;

    // ---------------------------------------------------------------
    // Sphere registers
    // ---------------------------------------------------------------
    t_coord          r_center [3];
    logic [N-2:0]    r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
            r_radius    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CENTER_X: r_center[0] <= i_cfg_data;
                REG_CENTER_Y: r_center[1] <= i_cfg_data;
                REG_CENTER_Z: r_center[2] <= i_cfg_data;
                REG_RADIUS:   r_radius    <= i_cfg_data[N-2:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline enable: everything moves unless the output is blocked
    // ---------------------------------------------------------------
    logic en;
    assign en         = !o_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // stage valid bits 1..6
    logic [6:1] r_v;
    logic [QW:0] r_sq_v;
    logic [DS:0] r_dv_v;   // index 0 is the sign, magnitude and overflow stage before the divider
    logic r_na_v;
    logic r_out_v;

    // ---------------------------------------------------------------
    // Stage 1: d = E - S, w = S - C
    // ---------------------------------------------------------------
    t_coord sv [3];
    t_coord ev [3];
    logic signed [N:0] n_d [3];
    logic signed [N:0] n_w [3];
    logic signed [N:0] r1_d [3];
    logic signed [N:0] r1_w [3];

    assign sv[0] = i_in_data.start_x;
    assign sv[1] = i_in_data.start_y;
    assign sv[2] = i_in_data.start_z;
    assign ev[0] = i_in_data.end_x;
    assign ev[1] = i_in_data.end_y;
    assign ev[2] = i_in_data.end_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d[i] = $signed({ev[i][N-1], ev[i]}) - $signed({sv[i][N-1], sv[i]});
            n_w[i] = $signed({sv[i][N-1], sv[i]}) - $signed({r_center[i][N-1], r_center[i]});
        end
    end

    // ---------------------------------------------------------------
    // Stages 2..7: dot products, discriminant
    // ---------------------------------------------------------------
    logic signed [2*N+1:0] r2_dd [3];
    logic signed [2*N+1:0] r2_dw [3];
    logic signed [2*N+1:0] r2_ww [3];
    logic [2*N-3:0]        r2_rr;

    logic signed [PW-1:0]  r3_a, r3_b, r3_k;

    logic [RW-1:0]         r4_bm, r4_km, r4_a;
    logic                  r4_ks, r4_deg;
    logic signed [PW-1:0]  r4_b;

    logic [2*H-1:0]        r5_bb_ll, r5_bb_lh, r5_bb_hh;
    logic [2*H-1:0]        r5_ak_ll, r5_ak_lh, r5_ak_hl, r5_ak_hh;
    logic                  r5_ks, r5_deg;
    logic signed [PW-1:0]  r5_b;
    logic [RW-1:0]         r5_a;

    logic [4*H-1:0]        r6_bb, r6_ak;
    logic                  r6_ks, r6_deg;
    logic signed [PW-1:0]  r6_b;
    logic [RW-1:0]         r6_a;

    logic signed [DW-1:0]  n_disc;

    assign n_disc = r6_ks ? $signed({2'b00, r6_bb} + {2'b00, r6_ak})
                          : $signed({2'b00, r6_bb} - {2'b00, r6_ak});

    // square root state, index k feeds stage k
    logic [XW-1:0] r_sq_x    [QW+1];
    logic [QW:0]   r_sq_rem  [QW+1];
    logic [QW-1:0] r_sq_root [QW+1];
    t_sq_side      r_sq_sd   [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r_v       <= {r_v[5:1], i_in_valid};
            r_sq_v[0] <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d <= n_d;
            r1_w <= n_w;

            for (int i = 0; i < 3; i++) begin
                r2_dd[i] <= r1_d[i] * r1_d[i];
                r2_dw[i] <= r1_d[i] * r1_w[i];
                r2_ww[i] <= r1_w[i] * r1_w[i];
            end
            r2_rr <= r_radius * r_radius;

            r3_a <= PW'(r2_dd[0]) + PW'(r2_dd[1]) + PW'(r2_dd[2]);
            r3_b <= PW'(r2_dw[0]) + PW'(r2_dw[1]) + PW'(r2_dw[2]);
            r3_k <= PW'(r2_ww[0]) + PW'(r2_ww[1]) + PW'(r2_ww[2])
                  - $signed({5'b00000, r2_rr});

            r4_bm  <= RW'(r3_b[PW-1] ? -r3_b : r3_b);
            r4_km  <= RW'(r3_k[PW-1] ? -r3_k : r3_k);
            r4_ks  <= r3_k[PW-1];
            r4_a   <= r3_a[RW-1:0];
            r4_deg <= r3_a[RW-1:0] < DEG_LIM;
            r4_b   <= r3_b;

            // partial products, H x H each
            r5_bb_ll <= r4_bm[H-1:0]  * r4_bm[H-1:0];
            r5_bb_lh <= r4_bm[H-1:0]  * r4_bm[RW-1:H];
            r5_bb_hh <= r4_bm[RW-1:H] * r4_bm[RW-1:H];
            r5_ak_ll <= r4_a[H-1:0]   * r4_km[H-1:0];
            r5_ak_lh <= r4_a[H-1:0]   * r4_km[RW-1:H];
            r5_ak_hl <= r4_a[RW-1:H]  * r4_km[H-1:0];
            r5_ak_hh <= r4_a[RW-1:H]  * r4_km[RW-1:H];
            r5_ks    <= r4_ks;
            r5_deg   <= r4_deg;
            r5_b     <= r4_b;
            r5_a     <= r4_a;

            r6_bb <= ((4*H)'(r5_bb_hh) << (2*H)) + ((4*H)'(r5_bb_lh) << (H+1))
                   + (4*H)'(r5_bb_ll);
            r6_ak <= ((4*H)'(r5_ak_hh) << (2*H))
                   + (((4*H)'(r5_ak_lh) + (4*H)'(r5_ak_hl)) << H)
                   + (4*H)'(r5_ak_ll);
            r6_ks  <= r5_ks;
            r6_deg <= r5_deg;
            r6_b   <= r5_b;
            r6_a   <= r5_a;

            // stage 7: radicand D * 2^(2F), clamped to 0 when D < 0
            r_sq_x[0]    <= n_disc[DW-1] ? '0
                                         : {2'b00, n_disc[DW-3:0], {(2*FRAC_BITS){1'b0}}};
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_sd[0]   <= '{deg: r6_deg, neg: n_disc[DW-1], b: r6_b, a: r6_a};
        end
    end

    // ---------------------------------------------------------------
    // Square root: one root bit per stage
    // ---------------------------------------------------------------
    for (genvar k = 0; k < QW; k++) begin : g_sqrt
        logic [QW+2:0] remn;
        logic [QW+2:0] trial;
        logic          take;

        assign remn  = {r_sq_rem[k], r_sq_x[k][XW-1:XW-2]};
        assign trial = {1'b0, r_sq_root[k], 2'b01};
        assign take  = remn >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_x[k+1]    <= r_sq_x[k] << 2;
                r_sq_rem[k+1]  <= take ? (QW+1)'(remn - trial) : remn[QW:0];
                r_sq_root[k+1] <= {r_sq_root[k][QW-2:0], take};
                r_sq_sd[k+1]   <= r_sq_sd[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Numerators -B*2^F +/- Q, then sign, magnitude and overflow
    // ---------------------------------------------------------------
    logic signed [NW-1:0] nb;
    logic signed [NW-1:0] r_na_n [2];
    t_sq_side             r_na_sd;
    logic [NW-1:0]        mag [2];

    assign nb = -(NW'(r_sq_sd[QW].b) <<< FRAC_BITS);

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            mag[l] = r_na_n[l][NW-1] ? NW'(-r_na_n[l]) : NW'(r_na_n[l]);
        end
    end

    logic [RW-1:0] r_dv_rem  [2][DS+1];
    logic [DS-1:0] r_dv_bits [2][DS+1];
    logic [DS-1:0] r_dv_q    [2][DS+1];
    t_dv_side      r_dv_sd   [DS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_na_v    <= 1'b0;
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_na_v    <= r_sq_v[QW];
            r_dv_v[0] <= r_na_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_na_n[0] <= nb + $signed({1'b0, (NW-1)'(r_sq_root[QW])});
            r_na_n[1] <= nb - $signed({1'b0, (NW-1)'(r_sq_root[QW])});
            r_na_sd   <= r_sq_sd[QW];

            r_dv_rem[0][0]  <= RW'(mag[0] >> DS);
            r_dv_bits[0][0] <= mag[0][DS-1:0];
            r_dv_q[0][0]    <= '0;
            r_dv_rem[1][0]  <= RW'(mag[1] >> DS);
            r_dv_bits[1][0] <= mag[1][DS-1:0];
            r_dv_q[1][0]    <= '0;
            r_dv_sd[0].deg <= r_na_sd.deg;
            r_dv_sd[0].neg <= r_na_sd.neg;
            r_dv_sd[0].a   <= r_na_sd.a;
            r_dv_sd[0].sgn <= {r_na_n[1][NW-1], r_na_n[0][NW-1]};
            r_dv_sd[0].ovf <= {(mag[1] >> DS) >= NW'(r_na_sd.a),
                               (mag[0] >> DS) >= NW'(r_na_sd.a)};
        end
    end

    // ---------------------------------------------------------------
    // Restoring division by A, two lanes, one quotient bit per stage
    // ---------------------------------------------------------------
    for (genvar j = 0; j < DS; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [RW:0] remn;
            logic        take;

            assign remn = {r_dv_rem[l][j], r_dv_bits[l][j][DS-1]};
            assign take = remn >= {1'b0, r_dv_sd[j].a};

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_rem[l][j+1]  <= take ? RW'(remn - {1'b0, r_dv_sd[j].a})
                                              : remn[RW-1:0];
                    r_dv_bits[l][j+1] <= r_dv_bits[l][j] << 1;
                    r_dv_q[l][j+1]    <= {r_dv_q[l][j][DS-2:0], take};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_sd[j+1] <= r_dv_sd[j];
            end
        end
    end

    // ---------------------------------------------------------------
    // Floor, saturate, classify
    // ---------------------------------------------------------------
    t_coord   root [2];
    logic [DS:0] qmag [2];
    t_ray_out n_out;
    t_dv_side fin;

    assign fin = r_dv_sd[DS];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (!fin.sgn[l]) begin
                qmag[l] = {1'b0, r_dv_q[l][DS]};
                root[l] = (fin.ovf[l] || qmag[l] > POS_MAX) ? t_coord'(POS_MAX)
                                                             : t_coord'(qmag[l]);
            end else begin
                // negative numerator: floor rounds the magnitude up
                qmag[l] = {1'b0, r_dv_q[l][DS]} + (DS+1)'(r_dv_rem[l][DS] != '0);
                root[l] = (fin.ovf[l] || qmag[l] > NEG_MAX) ? t_coord'(NEG_MAX)
                                                             : t_coord'(-qmag[l]);
            end
        end

        n_out = '0;
        if (fin.deg) begin
            n_out.status = ST_DEGEN;
        end else if (fin.neg) begin
            n_out.status = ST_NOROOT;
        end else begin
            n_out.root_plus  = root[0];
            n_out.root_minus = root[1];
            if (!root[1][N-1]) begin
                n_out.status       = ST_HIT;
                n_out.hit_distance = root[1];
            end else if (!root[0][N-1]) begin
                n_out.status       = ST_HIT;
                n_out.hit_distance = root[0];
            end else begin
                n_out.status = ST_BEHIND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv_v[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_data <= n_out;
        end
    end

    assign o_out_valid = r_out_v;

endmodule

>>> rtl/rsi_checker.sv
module rsi_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input rsi_pkg::t_ray_out               o_out_data
);
    import rsi_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // input is only held off by a blocked result
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with no result waiting");

    // rejected rays carry zero values
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_DEGEN || o_out_data.status == ST_NOROOT)
        |-> o_out_data.hit_distance == '0 && o_out_data.root_plus == '0
            && o_out_data.root_minus == '0)
        else $error("nonzero values on a rejected ray");

    a_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_BEHIND
        |-> o_out_data.hit_distance == '0 && o_out_data.root_plus < 0
            && o_out_data.root_minus < 0)
        else $error("behind case with a usable root");

    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_HIT
        |-> o_out_data.root_minus <= o_out_data.root_plus
            && o_out_data.hit_distance >= 0
            && (o_out_data.hit_distance == o_out_data.root_minus
                || o_out_data.hit_distance == o_out_data.root_plus))
        else $error("hit distance not a nonnegative root");

endmodule

bind ray_sphere_intersect_core rsi_checker u_rsi_checker (.*);

>>> test/tb_ray_sphere_intersect_core.sv
`timescale 1ns / 100ps

module tb_ray_sphere_intersect_core;
    import rsi_pkg::*;

    typedef logic signed [255:0] t_wide;

    localparam int PIPE_DEPTH = 3 * COORD_BITS + FRAC_BITS_DEF + 14;
    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD = 600;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd5;
    localparam t_coord ONE = 32'sh0001_0000;
    localparam t_coord CMAX = 32'sh7FFF_FFFF;
    localparam t_coord CMIN = 32'sh8000_0000;

    // Expected-result store plus its own copy of the sphere registers.
    class ray_scoreboard;
        t_coord cen_x, cen_y, cen_z;
        logic [COORD_BITS-2:0] radius;
        t_ray_out pending_q[$];
        int n_fail, n_checked;
        int n_status[4];

        function new();
            cen_x = '0; cen_y = '0; cen_z = '0; radius = '0;
            n_fail = 0; n_checked = 0;
            foreach (n_status[i]) n_status[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] val);
            case (idx)
                REG_CENTER_X: cen_x = val;
                REG_CENTER_Y: cen_y = val;
                REG_CENTER_Z: cen_z = val;
                REG_RADIUS:   radius = val[COORD_BITS-2:0];
                default: ;
            endcase
        endfunction

        function t_wide isqrt(t_wide x);
            logic [255:0] v, res, bit_w;
            v = x; res = '0; bit_w = 256'd1 << 254;
            while (bit_w != 0) begin
                if (v >= res + bit_w) begin
                    v = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            return res;
        endfunction

        // floor division (den > 0) then clamp to the coordinate range
        function t_coord floor_div_sat(t_wide num, t_wide den);
            t_wide q;
            q = num / den;
            if (num < 0 && (num % den) != 0) q = q - 1;
            if (q > t_wide'(CMAX)) q = t_wide'(CMAX);
            if (q < t_wide'(CMIN)) q = t_wide'(CMIN);
            return q[COORD_BITS-1:0];
        endfunction

        function void note_ray(t_ray_in r);
            t_wide s[3], e[3], c[3], dd, ww, a_sq, b_half, k_off, disc, q_root, nb, rr;
            t_ray_out res;
            s[0] = $signed(r.start_x); s[1] = $signed(r.start_y); s[2] = $signed(r.start_z);
            e[0] = $signed(r.end_x);   e[1] = $signed(r.end_y);   e[2] = $signed(r.end_z);
            c[0] = $signed(cen_x);     c[1] = $signed(cen_y);     c[2] = $signed(cen_z);
            a_sq = 0; b_half = 0; k_off = 0;
            for (int i = 0; i < 3; i++) begin
                dd = e[i] - s[i];
                ww = s[i] - c[i];
                a_sq = a_sq + dd * dd;
                b_half = b_half + dd * ww;
                k_off = k_off + ww * ww;
            end
            rr = {225'b0, radius};
            k_off = k_off - rr * rr;
            res = '0;
            if (a_sq * 10000 < (t_wide'(1) <<< (2 * FRAC_BITS_DEF))) begin
                res.status = ST_DEGEN;
            end else begin
                disc = b_half * b_half - a_sq * k_off;
                if (disc < 0) begin
                    res.status = ST_NOROOT;
                end else begin
                    q_root = isqrt(disc <<< (2 * FRAC_BITS_DEF));
                    nb = -(b_half <<< FRAC_BITS_DEF);
                    res.root_plus = floor_div_sat(nb + q_root, a_sq);
                    res.root_minus = floor_div_sat(nb - q_root, a_sq);
                    if (res.root_minus >= 0) begin
                        res.status = ST_HIT;
                        res.hit_distance = res.root_minus;
                    end else if (res.root_plus >= 0) begin
                        res.status = ST_HIT;
                        res.hit_distance = res.root_plus;
                    end else begin
                        res.status = ST_BEHIND;
                    end
                end
            end
            pending_q.push_back(res);
        endfunction

        function void check_result(t_ray_out got);
            t_ray_out exp_r;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, got);
                n_fail++;
                return;
            end
            exp_r = pending_q.pop_front();
            n_checked++;
            n_status[exp_r.status]++;
            if (got.status !== exp_r.status) begin
                $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
                n_fail++;
            end
            if (got.hit_distance !== exp_r.hit_distance) begin
                $display("%0t: hit_distance exp %h got %h", $realtime,
                         exp_r.hit_distance, got.hit_distance);
                n_fail++;
            end
            if (got.root_plus !== exp_r.root_plus) begin
                $display("%0t: root_plus exp %h got %h", $realtime,
                         exp_r.root_plus, got.root_plus);
                n_fail++;
            end
            if (got.root_minus !== exp_r.root_minus) begin
                $display("%0t: root_minus exp %h got %h", $realtime,
                         exp_r.root_minus, got.root_minus);
                n_fail++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [COORD_BITS-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_ray_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_ray_out o_out_data;

    ray_scoreboard sb = new();
    bit quiet = 1'b0;           // no idling on either side while set
    bit pressure_req = 1'b0;    // asks the sink for one long stall
    int n_rays = 0;
    int idle_cycles = 0;

    always #4 i_clk = ~i_clk;

    ray_sphere_intersect_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Sink: checks every result transfer and draws its own stall pattern.
    initial begin
        int hold, long_left;
        hold = 0; long_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_data);
                hold = quiet ? 0 : $urandom_range(0, 10);
            end
            if (pressure_req) begin
                pressure_req = 1'b0;
                long_left = LONG_HOLD;
            end
            if (long_left > 0) begin
                long_left--;
                i_out_stall <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: any transfer on either side resets the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Leaves the write enable high; the caller drops it after its last write.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic set_sphere(t_coord cx, t_coord cy, t_coord cz, logic [31:0] rad);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, rad);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Every ray makes exactly one result, so an empty store means the pipe is empty.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // One input transfer; valid stays high across back-to-back rays.
    task automatic send_ray(t_ray_in r);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_ray(r);
        n_rays++;
    endtask

    function automatic t_ray_in make_ray(t_coord sx, t_coord sy, t_coord sz,
                                         t_coord ex, t_coord ey, t_coord ez);
        t_ray_in r;
        r.start_x = sx; r.start_y = sy; r.start_z = sz;
        r.end_x = ex;   r.end_y = ey;   r.end_z = ez;
        return r;
    endfunction

    function automatic t_coord jitter(int span_log2);
        return t_coord'($urandom_range(0, (1 << span_log2) - 1)) - t_coord'(1 << (span_log2 - 1));
    endfunction

    function automatic t_coord corner();
        case ($urandom_range(0, 3))
            0: return CMAX;
            1: return CMIN;
            2: return '0;
            default: return -1;
        endcase
    endfunction

    function automatic t_ray_in random_ray();
        t_ray_in r;
        int pick, sc;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            // aimed at the center from a nearby start, end point near the center
            sc = $urandom_range(14, 24);
            r.start_x = sb.cen_x + jitter(sc);
            r.start_y = sb.cen_y + jitter(sc);
            r.start_z = sb.cen_z + jitter(sc);
            r.end_x = sb.cen_x + jitter(18);
            r.end_y = sb.cen_y + jitter(18);
            r.end_z = sb.cen_z + jitter(18);
        end else if (pick < 70) begin
            r = make_ray(jitter(20), jitter(20), jitter(20), jitter(20), jitter(20), jitter(20));
        end else if (pick < 85) begin
            r = make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 95) begin
            // end within a few hundred raw units of start: degenerate or nearly so
            r.start_x = $urandom; r.start_y = $urandom; r.start_z = $urandom;
            r.end_x = r.start_x + jitter(10);
            r.end_y = r.start_y + jitter(10);
            r.end_z = r.start_z + jitter(10);
        end else begin
            r = make_ray(corner(), corner(), corner(), corner(), corner(), corner());
        end
        return r;
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unit sphere at the origin; a write to an unused index must change nothing
        set_sphere('0, '0, '0, ONE);
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        i_cfg_we <= 1'b0;

        // directed rays
        send_ray(make_ray(-2 * ONE, '0, '0, -ONE, '0, '0));      // hit from outside
        send_ray(make_ray('0, '0, '0, ONE, '0, '0));             // start inside
        send_ray(make_ray(2 * ONE, '0, '0, 3 * ONE, '0, '0));    // both roots behind
        send_ray(make_ray('0, 2 * ONE, '0, ONE, 2 * ONE, '0));   // miss
        send_ray(make_ray('0, ONE, '0, ONE, ONE, '0));           // tangent
        send_ray(make_ray(ONE, ONE, ONE, ONE, ONE, ONE));        // zero length
        send_ray(make_ray('0, '0, '0, 32'sd300, 32'sd300, 32'sd300)); // just too short
        send_ray(make_ray('0, '0, '0, 32'sd700, '0, '0));        // short but usable
        send_ray(make_ray(-100 * ONE, '0, '0, -100 * ONE + 700, '0, '0)); // large positive roots
        send_ray(make_ray(100 * ONE, '0, '0, 100 * ONE + 700, '0, '0));   // large negative roots
        send_ray(make_ray(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        send_ray(make_ray(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        send_ray(make_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        send_ray(make_ray(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN));
        send_ray(make_ray(CMIN, '0, '0, CMAX, '0, '0));
        send_ray(make_ray(-1, -1, -1, '0, '0, '0));
        send_ray(make_ray(-ONE / 2, '0, '0, ONE / 2, '0, '0));

        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: set_sphere(jitter(22), jitter(22), jitter(22), $urandom_range(1, 1 << 20));
                1: set_sphere(CMAX, CMAX, CMAX, 32'h7FFF_FFFF);
                2: set_sphere(CMIN, CMIN, CMIN, 32'hFFFF_FFFF); // top radius bit dropped
                3: set_sphere('0, '0, '0, '0);
                4: set_sphere($urandom, $urandom, $urandom, $urandom);
                default: set_sphere(jitter(20), jitter(20), jitter(20), 5 * ONE);
            endcase
            quiet = (p == 3);
            for (int k = 0; k < 215; k++) begin
                // sink holds off long enough for the pipe to fill and back up
                if (p == 5 && k == 60) pressure_req = 1'b1;
                send_ray(random_ray());
            end
        end

        drain();
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
        $display("%0d rays sent, %0d results checked over 7 sphere settings", n_rays,
                 sb.n_checked);
        $display("hit %0d, degenerate %0d, no root %0d, behind %0d", sb.n_status[ST_HIT],
                 sb.n_status[ST_DEGEN], sb.n_status[ST_NOROOT], sb.n_status[ST_BEHIND]);
        if (sb.n_fail == 0 && sb.pending_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
